// ===== rtl/taqt_pkg.sv =====
// shared types and constants for the rule 184 traffic road block
`default_nettype none

package taqt_pkg;

   // default road length
   localparam int CELLS_DEFAULT = 256;

   // run lengths are 9 bits wide and saturate at the top code
   localparam int          RUN_W   = 9;
   localparam logic [8:0]  RUN_SAT = 9'd511;

   // request codes
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [7:0] cell_index;
      logic       cell_value;
      logic       new_car;
   } taqt_req_type;

   typedef struct packed {
      logic [RUN_W-1:0] longest_run;
      logic [RUN_W-1:0] running_max;
   } taqt_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } taqt_state_type;

endpackage : taqt_pkg

`default_nettype wire

// ===== rtl/traffic_automaton_with_queue_tracking.sv =====
// top level of the rule 184 traffic road with longest-run tracking
`default_nettype none

// Rule 184 traffic road. The road is a row of CELLS one-bit cells held in
// flip-flops, 1 meaning a car. A load item writes one cell (an index of CELLS
// or more writes nothing); a tick item advances every cell by rule 184 at
// once, with the cell beyond the right edge counted as empty so a car
// in the last cell leaves, and then puts new_car into cell 0. Every item
// returns one result: the longest run of occupied cells (after the write for
// a load, before the update for a tick) and the running maximum of the runs
// measured by ticks since reset. Runs saturate at 511. The run is measured by
// copying the row into a shift register and scanning it one cell per cycle:
// the item is accepted and the row copied, the copy is scanned, and then the
// maximum is folded and the output register loaded once it is free. One item
// is in work at a time; the next item is taken as soon as the result sits in
// the output register, even while the receiver still stalls it.
module traffic_automaton_with_queue_tracking #(
   parameter int CELLS = taqt_pkg::CELLS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire taqt_pkg::taqt_req_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output taqt_pkg::taqt_rsp_type     rsp_data
);

   import taqt_pkg::*;

   localparam int CNT_W = $clog2(CELLS);

   // control state
   taqt_state_type   state_ff, state_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RUN_W-1:0] max_ff, max_in;

   // road and scan copy
   logic [CELLS-1:0] road_ff, road_in;
   logic [CELLS-1:0] scan_ff, scan_in;

   // per-item payload
   logic             tick_ff, tick_in;
   logic [RUN_W-1:0] cur_ff, cur_in;
   logic [RUN_W-1:0] best_ff, best_in;
   taqt_rsp_type     rsp_ff, rsp_in;

   // fsm outputs
   logic req_take;
   logic scan_step;
   logic rsp_load;
   logic last_cell;
   logic rsp_free;

   logic [CELLS-1:0] road_written;
   logic [CELLS-1:0] road_advanced;
   logic [RUN_W-1:0] cur_next;

   assign last_cell = (pos_ff == CNT_W'(CELLS - 1));
   // output register empty or being emptied this cycle
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_cell) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // fsm outputs
   // ---------------------------------------------------------------
   always_comb begin
      req_stall = 1'b1;
      req_take  = 1'b0;
      scan_step = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            req_take  = req_valid;
         end
         ST_SCAN: begin
            scan_step = 1'b1;
         end
         ST_DONE: begin
            rsp_load = rsp_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // road: single cell write for a load, rule 184 for a tick
   // ---------------------------------------------------------------
   always_comb begin
      for (int i = 0; i < CELLS; i++) begin
         // a load whose index is past the end matches no cell
         road_written[i] = (32'(req_data.cell_index) == i) ? req_data.cell_value
                                                           : road_ff[i];
         // empty cell takes its left neighbor, occupied cell its right one;
         // beyond either edge counts as empty
         if (road_ff[i]) begin
            road_advanced[i] = (i < CELLS - 1) ? road_ff[(i + 1) % CELLS] : 1'b0;
         end else begin
            road_advanced[i] = (i > 0) ? road_ff[(i + CELLS - 1) % CELLS] : 1'b0;
         end
      end
   end

   always_comb begin
      road_in = road_ff;
      scan_in = scan_ff;
      tick_in = tick_ff;
      if (req_take) begin
         tick_in = (req_data.req_type == REQ_TICK);
         if (req_data.req_type == REQ_TICK) begin
            // scan sees the row before the update
            scan_in = road_ff;
            road_in = {road_advanced[CELLS-1:1], req_data.new_car};
         end else begin
            // scan sees the row after the write
            scan_in = road_written;
            road_in = road_written;
         end
      end else if (scan_step) begin
         scan_in = {1'b0, scan_ff[CELLS-1:1]};
      end
   end

   // ---------------------------------------------------------------
   // serial run measurement, one cell per cycle
   // ---------------------------------------------------------------
   always_comb begin
      if (!scan_ff[0]) begin
         cur_next = '0;
      end else if (cur_ff == RUN_SAT) begin
         cur_next = RUN_SAT;
      end else begin
         cur_next = cur_ff + RUN_W'(1);
      end
   end

   always_comb begin
      pos_in  = pos_ff;
      cur_in  = cur_ff;
      best_in = best_ff;
      if (req_take) begin
         pos_in  = '0;
         cur_in  = '0;
         best_in = '0;
      end else if (scan_step) begin
         pos_in  = pos_ff + CNT_W'(1);
         cur_in  = cur_next;
         best_in = (cur_next > best_ff) ? cur_next : best_ff;
      end
   end

   // ---------------------------------------------------------------
   // running maximum and output register
   // ---------------------------------------------------------------
   always_comb begin
      max_in       = max_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         // only a tick folds its run into the maximum
         if (tick_ff && (best_ff > max_ff)) begin
            max_in = best_ff;
         end
         rsp_in.longest_run = best_ff;
         rsp_in.running_max = max_in;
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         max_ff       <= '0;
         road_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         max_ff       <= max_in;
         road_ff      <= road_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      tick_ff <= tick_in;
      cur_ff  <= cur_in;
      best_ff <= best_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------

   // an accepted item starts a scan at the first cell
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_SCAN) && (pos_ff == '0))
      else $error("scan did not start after an accepted item");

   // the best run never trails the current run while scanning
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (best_ff >= cur_ff))
      else $error("best run below current run");

   // the running maximum never decreases
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (max_ff >= $past(max_ff)))
      else $error("running maximum decreased");

   // a result is only loaded into a free output register
   assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_valid_ff) |-> !rsp_stall)
      else $error("result overwritten while stalled");

endmodule : traffic_automaton_with_queue_tracking

`default_nettype wire

// ===== tb/traffic_automaton_with_queue_tracking_test.sv =====
// testbench for the rule 184 traffic road with longest-run and running-maximum tracking
`default_nettype none

module traffic_automaton_with_queue_tracking_test;
   timeunit 1ns;
   timeprecision 1ps;

   import taqt_pkg::*;

   localparam int ROAD_LEN       = CELLS_DEFAULT;
   // receiver hold-off: starts once this many results have gone by
   localparam int HOLD_AT        = 200;
   localparam int HOLD_CYCLES    = 1500;
   // cycles with no handshake on either side before giving up
   localparam int WATCHDOG_LIMIT = 8000;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   taqt_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   taqt_rsp_type rsp_data;

   // items waiting for the driver, results waiting for the checker
   taqt_req_type pending_items[$];
   taqt_rsp_type expected_results[$];

   // predicted road and running maximum
   logic [ROAD_LEN-1:0] road_model;
   logic [RUN_W-1:0]    max_model;

   int   error_count    = 0;
   int   rsp_count      = 0;
   int   full_road_left = 2;
   int   send_gap;
   logic send_idle;
   int   stall_left;
   int   rsp_seen;
   logic hold_done;
   int   quiet_cycles;
   logic tail_phase = 1'b0;

   traffic_automaton_with_queue_tracking dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // longest run of occupied cells, saturated to the 9-bit top code
   function automatic logic [RUN_W-1:0] longest_occupied(input logic [ROAD_LEN-1:0] cells);
      int best;
      int cur;
      best = 0;
      cur  = 0;
      for (int i = 0; i < ROAD_LEN; i++) begin
         if (cells[i]) begin
            cur++;
            if (cur > best) best = cur;
         end else begin
            cur = 0;
         end
      end
      if (best > int'(RUN_SAT)) best = int'(RUN_SAT);
      return best[RUN_W-1:0];
   endfunction

   // one rule 184 step; both neighbours beyond the edges count as empty
   function automatic logic [ROAD_LEN-1:0] rule184_step(input logic [ROAD_LEN-1:0] cells);
      logic [ROAD_LEN-1:0] nxt;
      logic                left_nb;
      logic                right_nb;
      for (int i = 0; i < ROAD_LEN; i++) begin
         left_nb  = (i > 0) ? cells[i-1] : 1'b0;
         right_nb = (i < ROAD_LEN - 1) ? cells[i+1] : 1'b0;
         nxt[i]   = cells[i] ? right_nb : left_nb;
      end
      return nxt;
   endfunction

   function automatic void queue_item(input logic kind, input logic [7:0] idx,
                                      input logic val, input logic car);
      taqt_req_type item;
      item.req_type   = kind;
      item.cell_index = idx;
      item.cell_value = val;
      item.new_car    = car;
      pending_items.push_back(item);
   endfunction

   // random traffic built from short segments: scattered loads at a chosen
   // density, runs of ticks, solid blocks of cars, a fully packed road now
   // and then, and single noise items
   task automatic add_random(input int count);
      int added;
      int seg;
      int n;
      int pct;
      logic [7:0] start;
      added = 0;
      while (added < count) begin
         seg = $urandom_range(0, 9);
         if (seg == 0 && full_road_left != 0) begin
            // every cell occupied, then a few ticks: runs reach the full road
            full_road_left--;
            for (int i = 0; i < ROAD_LEN; i++)
               queue_item(REQ_LOAD, 8'(i), 1'b1, 1'($urandom_range(0, 1)));
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
               queue_item(REQ_TICK, 8'($urandom), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            added += ROAD_LEN + n;
         end else if (seg <= 4) begin
            n   = $urandom_range(1, 12);
            pct = $urandom_range(0, 100);
            for (int i = 0; i < n; i++)
               queue_item(REQ_LOAD, 8'($urandom), 1'($urandom_range(0, 99) < pct),
                          1'($urandom_range(0, 1)));
            added += n;
         end else if (seg <= 7) begin
            n   = $urandom_range(1, 8);
            pct = $urandom_range(0, 100);
            for (int i = 0; i < n; i++)
               queue_item(REQ_TICK, 8'($urandom), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 99) < pct));
            added += n;
         end else if (seg == 8) begin
            // solid block of cars, wrapping around the index range
            start = 8'($urandom);
            n     = $urandom_range(1, 40);
            for (int i = 0; i < n; i++)
               queue_item(REQ_LOAD, start + 8'(i), 1'b1, 1'($urandom_range(0, 1)));
            queue_item(REQ_TICK, 8'($urandom), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
            added += n + 1;
         end else begin
            queue_item(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
            added++;
         end
      end
   endtask

   // sender pause: nothing offered until every result is back
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0);
   endtask

   // driver: presents queued items, holds each one until accepted, and idles
   // in random bursts; bursts tend to chain so that the end of a gap lands
   // anywhere in the block's scan
   always @(posedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
         send_idle <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (!tail_phase && pending_items.size() != 0
                      && $urandom_range(0, 99) < (send_idle ? 94 : 15)) begin
            req_valid <= 1'b0;
            send_gap  <= $urandom_range(0, 8);
            send_idle <= 1'b1;
         end else if (pending_items.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_items.pop_front();
            send_idle <= 1'b0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stall bursts, plus one long hold-off so the block
   // fills up and has to stall its input while the driver keeps offering
   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         rsp_seen   <= 0;
         hold_done  <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) rsp_seen <= rsp_seen + 1;
         if (stall_left != 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (!hold_done && rsp_seen >= HOLD_AT) begin
            rsp_stall  <= 1'b1;
            stall_left <= HOLD_CYCLES - 1;
            hold_done  <= 1'b1;
         end else if (!tail_phase && $urandom_range(0, 11) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 8);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // checker and predictor in one process: a result is checked before the
   // item accepted at the same edge is predicted
   always @(posedge clock) begin : monitor
      taqt_rsp_type     want;
      logic [RUN_W-1:0] run;
      if (reset) begin
         road_model = '0;
         max_model  = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               if (error_count < 10)
                  $display("result %0d arrived with nothing expected: run %0d max %0d",
                           rsp_count, rsp_data.longest_run, rsp_data.running_max);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.longest_run !== want.longest_run
                   || rsp_data.running_max !== want.running_max) begin
                  if (error_count < 10)
                     $display("mismatch on result %0d: expected run %0d max %0d, got run %0d max %0d",
                              rsp_count, want.longest_run, want.running_max,
                              rsp_data.longest_run, rsp_data.running_max);
                  error_count++;
               end
            end
            rsp_count++;
         end
         if (req_valid && !req_stall) begin
            if (req_data.req_type == REQ_LOAD) begin
               // a load measures after its write and leaves the maximum alone
               if (int'(req_data.cell_index) < ROAD_LEN)
                  road_model[req_data.cell_index] = req_data.cell_value;
               run = longest_occupied(road_model);
            end else begin
               // a tick measures first, then moves the cars, then lets one in
               run = longest_occupied(road_model);
               if (run > max_model) max_model = run;
               road_model    = rule184_step(road_model);
               road_model[0] = req_data.new_car;
            end
            want.longest_run = run;
            want.running_max = max_model;
            expected_results.push_back(want);
         end
      end
   end

   // watchdog: too long without any handshake ends the run
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: a load ignores new_car and does not touch the maximum
      queue_item(REQ_LOAD, 8'd255, 1'b1, 1'b1);
      // a tick ignores index and value; the car in the last cell leaves
      queue_item(REQ_TICK, 8'd255, 1'b1, 1'b0);
      // empty road, car enters cell 0
      queue_item(REQ_TICK, 8'd0, 1'b0, 1'b1);
      // left edge: cell 0 empties behind the moving car
      queue_item(REQ_TICK, 8'd0, 1'b0, 1'b0);
      // loads build a run of three without raising the maximum
      queue_item(REQ_LOAD, 8'd0, 1'b1, 1'b0);
      queue_item(REQ_LOAD, 8'd2, 1'b1, 1'b0);
      queue_item(REQ_TICK, 8'd0, 1'b0, 1'b1);
      // run against the right edge, then the front car drives off
      queue_item(REQ_LOAD, 8'd254, 1'b1, 1'b0);
      queue_item(REQ_LOAD, 8'd253, 1'b1, 1'b0);
      queue_item(REQ_LOAD, 8'd255, 1'b1, 1'b0);
      queue_item(REQ_TICK, 8'd0, 1'b0, 1'b0);
      // alternating index bit patterns
      queue_item(REQ_LOAD, 8'd128, 1'b0, 1'b1);
      queue_item(REQ_LOAD, 8'd127, 1'b1, 1'b0);
      queue_item(REQ_LOAD, 8'h55, 1'b1, 1'b1);
      queue_item(REQ_LOAD, 8'hAA, 1'b1, 1'b0);
      // cars pile in from the left
      queue_item(REQ_TICK, 8'hFF, 1'b1, 1'b1);
      queue_item(REQ_TICK, 8'hFF, 1'b1, 1'b1);
      queue_item(REQ_TICK, 8'hFF, 1'b1, 1'b1);
      // clearing both edge cells
      queue_item(REQ_LOAD, 8'd255, 1'b0, 1'b0);
      queue_item(REQ_LOAD, 8'd0, 1'b0, 1'b1);
      wait_drained();

      // first random batch; the long receiver hold-off falls inside it
      add_random(600);
      wait_drained();

      add_random(580);
      // last stretch runs with no idling on either side
      do @(negedge clock);
      while (pending_items.size() > 120);
      tail_phase <= 1'b1;
      wait_drained();

      // let a stray extra result show up if there is one
      repeat (ROAD_LEN + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule : traffic_automaton_with_queue_tracking_test

`default_nettype wire

// ===== traffic_automaton_with_queue_tracking.f =====
rtl/taqt_pkg.sv
rtl/traffic_automaton_with_queue_tracking.sv
tb/traffic_automaton_with_queue_tracking_test.sv
